### src/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg: shared types and constants of the radix text converter
// Holds field widths, character codes and the divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

	localparam int VALUE_W     = 32;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 5;
	localparam int CHAR_W      = 7;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = 5;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd65;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'd45;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 5'd10;

	typedef struct packed {
		logic                 start;
		logic [VALUE_W-1:0]   dividend;
		logic [RADIX_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [VALUE_W-1:0]   quotient;
		logic [DIGIT_W-1:0]   remainder;
	} div_rsp_t;

	// Map a digit value to its ASCII character: 0-9 to '0'-'9', 10-31 to 'A'-'V'.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d >= DIGIT_TEN) begin
			c = CHAR_ALPHA + {2'b00, d - DIGIT_TEN};
		end else begin
			c = CHAR_ZERO + {2'b00, d};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### src/itra_ram.sv
// ----------------------------------------------------------------------------
// itra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/itra_div.sv
// ----------------------------------------------------------------------------
// itra_div: bit-serial restoring divider
// Divides a 32-bit magnitude by the base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_div (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire itra_pkg::div_req_t req,
	output itra_pkg::div_rsp_t      rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [itra_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [itra_pkg::VALUE_W-1:0]    quo_q;
	logic [itra_pkg::DIGIT_W-1:0]    rem_q;
	logic [itra_pkg::RADIX_W-1:0]    divisor_q;

	logic [itra_pkg::DIGIT_W:0]      trial;
	logic                            fits;
	logic [itra_pkg::DIGIT_W:0]      diff;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[itra_pkg::VALUE_W-1]};
		fits  = (trial >= divisor_q);
		diff  = trial - divisor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itra_pkg::DIV_CNT_W'(itra_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[itra_pkg::VALUE_W-2:0], fits};
			rem_q <= fits ? diff[itra_pkg::DIGIT_W-1:0] : trial[itra_pkg::DIGIT_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

### src/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core: integer to radix text converter
// Turns one 32-bit integer into ASCII text in a base of 2 to 32, most
// significant character first, with a '-' in front of negative decimals.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  input    | in_valid / in_ready    | value (32, signed)
//  output   | out_valid / out_ready  | character (7), last (1)
//  config   | cfg_wr_en              | cfg_wr_data (6) = radix
//
// One number at a time. Each digit costs one bit-serial division by the base:
// a start state, 32 divider steps and a write, per digit (10 digits for a
// full decimal, 32 for a full binary value). Each digit character then goes
// through RAM read, load and hand over, and the '-' through stage and hand
// over, plus any output stall. in_ready is high only while idle. Reset sets
// radix to 10 and empties the control path; the digit RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii_core #(
	parameter int MAX_DIGITS = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire signed [itra_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [itra_pkg::CHAR_W-1:0]         character,
	output logic                                last,
	input  wire                                 cfg_wr_en,
	input  wire  [itra_pkg::RADIX_W-1:0]        cfg_wr_data
);

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_LOAD  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]                      state_q;
	logic [itra_pkg::RADIX_W-1:0]    radix_q;
	logic [itra_pkg::RADIX_W-1:0]    base_q;
	logic [itra_pkg::VALUE_W-1:0]    mag_q;
	logic [CNT_W-1:0]                count_q;
	logic [ADDR_W-1:0]               idx_q;
	logic                            neg_q;
	logic                            out_valid_q;
	logic [itra_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;

	logic                            in_acc;
	logic                            out_acc;
	logic                            in_neg;
	logic [itra_pkg::VALUE_W-1:0]    in_mag;
	logic                            zero_wr;
	logic [CNT_W-1:0]                count_nx;
	logic                            more;

	itra_pkg::div_req_t              div_req;
	itra_pkg::div_rsp_t              div_rsp;

	logic                            ram_we;
	logic [ADDR_W-1:0]               ram_waddr;
	logic [itra_pkg::DIGIT_W-1:0]    ram_wdata;
	logic [itra_pkg::DIGIT_W-1:0]    ram_rdata;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// Only decimal shows a sign; other bases read the raw 32-bit pattern.
	always_comb begin
		in_neg   = (radix_q == itra_pkg::RADIX_DEC) && value[itra_pkg::VALUE_W-1];
		in_mag   = in_neg ? (itra_pkg::VALUE_W'(0) - $unsigned(value)) : $unsigned(value);
		zero_wr  = in_acc && (in_mag == '0);
		count_nx = count_q + 1'b1;
		more     = (div_rsp.quotient != '0) && (count_nx < CNT_W'(MAX_DIGITS));
	end

	// Digits land least significant first; zero writes a single '0' digit.
	always_comb begin
		ram_we    = zero_wr || ((state_q == S_WAIT) && div_rsp.done);
		ram_waddr = zero_wr ? '0 : count_q[ADDR_W-1:0];
		ram_wdata = zero_wr ? '0 : div_rsp.remainder;
	end

	always_comb begin
		div_req.start    = (state_q == S_START);
		div_req.dividend = mag_q;
		div_req.divisor  = base_q;
	end

	itra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	itra_ram #(
		.WIDTH (itra_pkg::DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Radix register: drop writes outside two to thirty-two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itra_pkg::RADIX_RESET;
		end else if (cfg_wr_en &&
				(cfg_wr_data inside {[itra_pkg::RADIX_MIN:itra_pkg::RADIX_MAX]})) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mag_q       <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			neg_q       <= 1'b0;
			base_q      <= itra_pkg::RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						neg_q   <= in_neg;
						mag_q   <= in_mag;
						base_q  <= radix_q;
						if (in_mag == '0) begin
							// Zero: one '0' digit, straight to output.
							count_q <= CNT_W'(1);
							idx_q   <= '0;
							state_q <= S_RD;
						end else begin
							count_q <= '0;
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						mag_q   <= div_rsp.quotient;
						count_q <= count_nx;
						if (more) begin
							state_q <= S_START;
						end else begin
							// Start emission at the digit just written.
							idx_q   <= count_q[ADDR_W-1:0];
							state_q <= neg_q ? S_SIGN : S_RD;
						end
					end
				end
				S_SIGN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else if (neg_q) begin
							// Sign went out; digits follow at the same index.
							neg_q   <= 1'b0;
							state_q <= S_RD;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload: load only when a character is staged, hold while stalled.
	always_ff @(posedge clk) begin
		if (state_q == S_SIGN) begin
			char_q <= itra_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == S_LOAD) begin
			char_q <= itra_pkg::digit_char(ram_rdata);
			last_q <= (idx_q == '0);
		end
	end

endmodule

`default_nettype wire

### sim/itra_text_checker.sv
// ----------------------------------------------------------------------------
// itra_text_checker: scoreboard for the radix text converter
// Tracks the radix register, predicts each number's text and compares every
// character handed over by the block with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_text_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_ready,
	input  wire [itra_pkg::VALUE_W-1:0]   value,
	input  wire                           out_valid,
	input  wire                           out_ready,
	input  wire [itra_pkg::CHAR_W-1:0]    character,
	input  wire                           last,
	input  wire                           cfg_wr_en,
	input  wire [itra_pkg::RADIX_W-1:0]   cfg_wr_data,
	output int                            mismatches,
	output int                            chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS_MAX = 32;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [itra_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	text_char_t                   text_due[$];
	logic [itra_pkg::RADIX_W-1:0] radix_shadow = itra_pkg::RADIX_RESET;
	int                           error_total  = 0;

	// Queue the characters of one number, most significant first.
	function automatic void predict_text(input logic [itra_pkg::VALUE_W-1:0] bits,
			input logic [itra_pkg::RADIX_W-1:0] base);
		logic [itra_pkg::DIGIT_W-1:0] digits [DIGITS_MAX];
		logic [itra_pkg::VALUE_W-1:0] magnitude;
		logic [itra_pkg::VALUE_W-1:0] rem;
		logic                         negative;
		int                           count;
		text_char_t                   tc;
		negative  = (base == itra_pkg::RADIX_DEC) && bits[itra_pkg::VALUE_W-1];
		magnitude = negative ? (~bits + 1'b1) : bits;
		count     = 0;
		while (magnitude != '0 && count < DIGITS_MAX) begin
			rem            = magnitude % base;
			digits[count]  = rem[itra_pkg::DIGIT_W-1:0];
			magnitude      = magnitude / base;
			count++;
		end
		// zero still prints one digit
		if (count == 0) begin
			digits[0] = '0;
			count     = 1;
		end
		if (negative) begin
			tc.code = itra_pkg::CHAR_MINUS;
			tc.last = 1'b0;
			text_due.push_back(tc);
		end
		for (int k = count - 1; k >= 0; k--) begin
			if (digits[k] >= itra_pkg::DIGIT_TEN) begin
				tc.code = itra_pkg::CHAR_ALPHA +
					itra_pkg::CHAR_W'(digits[k] - itra_pkg::DIGIT_TEN);
			end else begin
				tc.code = itra_pkg::CHAR_ZERO + itra_pkg::CHAR_W'(digits[k]);
			end
			tc.last = (k == 0);
			text_due.push_back(tc);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		text_char_t want;
		if (!arst_n) begin
			radix_shadow = itra_pkg::RADIX_RESET;
			text_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				predict_text(value, radix_shadow);
			end
			if (out_valid && out_ready) begin
				if (text_due.size() == 0) begin
					if (error_total < REPORT_MAX) begin
						$display("%0t: unexpected character %h last %b",
							$realtime, character, last);
					end
					error_total++;
				end else begin
					want = text_due.pop_front();
					if (want.code !== character || want.last !== last) begin
						if (error_total < REPORT_MAX) begin
							$display("%0t: expected character %h last %b, got %h last %b",
								$realtime, want.code, want.last, character, last);
						end
						error_total++;
					end
				end
			end
			// out-of-range writes leave the register alone
			if (cfg_wr_en && cfg_wr_data >= itra_pkg::RADIX_MIN &&
					cfg_wr_data <= itra_pkg::RADIX_MAX) begin
				radix_shadow = cfg_wr_data;
			end
		end
		mismatches    <= error_total;
		chars_pending <= text_due.size();
	end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the radix text converter
// Drives numbers through the valid/ready input in several bases, with a
// directed opening and a random body under three idling patterns and a long
// output hold-off; the checker beside the block predicts and compares text.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest legal quiet stretch: a 32-digit binary number or the output
	// hold-off below; take several times the larger.
	localparam int STALL_LIMIT     = 8000;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int SETTLE_CYCLES   = 200;
	localparam int PHASES_PER_MODE = 8;
	localparam int ITEMS_PER_PHASE = 21;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [itra_pkg::VALUE_W-1:0]   value       = '0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic [itra_pkg::CHAR_W-1:0]    character;
	logic                           last;
	logic                           cfg_wr_en   = 1'b0;
	logic [itra_pkg::RADIX_W-1:0]   cfg_wr_data = '0;

	int mismatches;
	int chars_pending;

	// idling odds, in percent per cycle
	int send_idle_pct = 10;
	int recv_idle_pct = 88;

	// hold-off requests: the stimulus bumps one, the receiver the other
	int holds_asked   = 0;
	int holds_granted = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	integer_to_radix_ascii_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	itra_text_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.mismatches   (mismatches),
		.chars_pending(chars_pending)
	);

	// Write the radix register; a wait with the enable low keeps back-to-back writes apart.
	task automatic set_radix(input logic [itra_pkg::RADIX_W-1:0] r);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one number and hold it until the block takes it.
	task automatic send_value(input logic [itra_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every predicted character has come out.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (chars_pending != 0);
	endtask

	// Mostly short numbers, so binary conversions of full words stay rare
	// enough to keep the run short.
	function automatic logic [itra_pkg::VALUE_W-1:0] pick_value();
		logic [itra_pkg::VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: v = $urandom;
			1: v = $urandom_range(40);
			2: v = -$urandom_range(40, 1);
			3: v = $urandom_range(100000);
			4: v = 32'h8000_0000 + $urandom_range(2) - 1;
			default: v = $urandom >> $urandom_range(31);
		endcase
		return v;
	endfunction

	function automatic logic [itra_pkg::RADIX_W-1:0] pick_radix();
		logic [itra_pkg::RADIX_W-1:0] r;
		case ($urandom_range(7))
			0: r = itra_pkg::RADIX_MIN;
			1: r = itra_pkg::RADIX_MAX;
			2: r = itra_pkg::RADIX_DEC;
			3: r = 6'd16;
			default: r = itra_pkg::RADIX_W'($urandom_range(itra_pkg::RADIX_MAX,
				itra_pkg::RADIX_MIN));
		endcase
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (holds_granted != holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				holds_granted++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [itra_pkg::RADIX_W-1:0] bad_radix;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decimal from reset: zero, single digits, sign handling, both ends of
		// the range including the most negative value.
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(-32'sd1);
		send_value(-32'sd10);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd123456789);
		drain();

		// Smallest base: longest text, negatives read as unsigned.
		set_radix(itra_pkg::RADIX_MIN);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'hAAAA_AAAA);
		drain();

		// Largest base: top digit 'V', letter boundary at ten.
		set_radix(itra_pkg::RADIX_MAX);
		send_value(32'd31);
		send_value(32'd32);
		send_value(32'd10);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		drain();

		set_radix(6'd16);
		send_value(32'hDEAD_BEEF);
		send_value(32'h8000_0000);
		drain();

		// Writes outside 2..32 must be ignored: base stays sixteen.
		set_radix(6'd0);
		set_radix(6'd1);
		set_radix(6'd33);
		set_radix(6'd63);
		send_value(32'd255);
		drain();

		// Random body: sender-light/receiver-heavy idling, then the reverse,
		// then none; a long output hold-off fills the block in two modes.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 10; recv_idle_pct = 88; end
				1: begin send_idle_pct = 88; recv_idle_pct = 10; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int phase = 0; phase < PHASES_PER_MODE; phase++) begin
				drain();
				if ($urandom_range(3) == 0) begin
					bad_radix = ($urandom_range(1) == 0) ? 6'($urandom_range(1)) :
						6'($urandom_range(63, 33));
					set_radix(bad_radix);
				end
				set_radix(pick_radix());
				for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
					send_value(pick_value());
					if (k == 0 && phase == 0 && mode != 1) begin
						holds_asked++;
					end
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && chars_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
